// File: design/lgs_pkg.sv
// Shared types and constants of the life generation stencil unit.
// No dependencies; lgs_judge and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	// Default grid limits, handed to the top-level parameters.
	localparam int DEF_MAX_COLS = 512;
	localparam int DEF_MAX_ROWS = 512;

	// Configuration register layout.
	localparam int CFG_WIDTH = 10;
	localparam logic [CFG_WIDTH-1:0] GRID_COLS_RESET = 10'd300;
	localparam logic [CFG_WIDTH-1:0] GRID_ROWS_RESET = 10'd300;
	localparam logic REG_GRID_COLS = 1'b0;
	localparam logic REG_GRID_ROWS = 1'b1;

	// Smallest grid dimension the logic supports; smaller values act as this.
	localparam int MIN_GRID = 3;

	// Which neighbour groups of the window lie inside the grid.
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
	} lgs_flags_t;

endpackage

`default_nettype wire

// File: design/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Reads return the old contents when the same address is written in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/lgs_col_cell.sv
// One column cell of the 3x3 window: holds three vertically stacked cells.
// Loads the column from its right-hand neighbor whenever the window shifts.
`timescale 1ns / 1ps
`default_nettype none

module lgs_col_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic [2:0] col_in,
	output logic      [2:0] col_out
);

	logic [2:0] col_q;

	// Column register, cleared at reset so an empty window reads as dead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

// File: design/lgs_judge.sv
// Neighbor count and B3/S23 rule for the cell in the middle of the window.
// Depends on lgs_pkg for the edge flag struct.
`timescale 1ns / 1ps
`default_nettype none

module lgs_judge
	import lgs_pkg::*;
(
	input  wire logic       [2:0] left_col,
	input  wire logic       [2:0] mid_col,
	input  wire logic       [2:0] right_col,
	input  wire lgs_flags_t       flags,
	output logic                  next_state,
	output logic            [3:0] count
);

	logic [2:0] row_mask;
	logic [2:0] l_m;
	logic [2:0] m_m;
	logic [2:0] r_m;
	logic       self_alive;

	// Mask out rows and the left column that fall outside the grid.
	always_comb begin
		row_mask = {flags.bot_ok, 1'b1, flags.top_ok};
		l_m = flags.left_ok ? (left_col & row_mask) : 3'b000;
		m_m = mid_col & row_mask & 3'b101;
		r_m = right_col & row_mask;
		self_alive = mid_col[1];
	end

	// Sum of the eight neighbors.
	assign count = 4'(l_m[0]) + 4'(l_m[1]) + 4'(l_m[2])
		+ 4'(m_m[0]) + 4'(m_m[2])
		+ 4'(r_m[0]) + 4'(r_m[1]) + 4'(r_m[2]);

	// Birth on three, survival on two or three.
	assign next_state = self_alive ? ((count == 4'd2) || (count == 4'd3)) : (count == 4'd3);

endmodule

`default_nettype wire

// File: design/life_generation_stencil_unit.sv
// Top level of the life generation stencil unit: position counters, line store,
// window cells, rule logic and output register. Depends on lgs_pkg, lgs_ram,
// lgs_col_cell and lgs_judge.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------------
//  input   | in_valid / in_ready | alive, frame_start
//  output  | out_valid/out_ready | next_alive, neighbour_count, last_cell
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// One item is accepted per clock unless a stalled output holds the pipeline. An
// item is read from the line store at acceptance, combined with the window in
// the next cycle, and its result, if any, is registered when stage one advances.
// The result for a cell belongs to the item accepted grid_cols+1 items after it.
// Reset clears the counters, the window and the pipeline; the line store is not
// cleared. Input is still taken while the result register drains.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_stencil_unit
	import lgs_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 alive,
	input  wire logic                 frame_start,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      next_alive,
	output logic      [3:0]           neighbour_count,
	output logic                      last_cell,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int ECW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 3);
	localparam int ROW_CAP = MAX_ROWS + 2;

	logic [CFG_WIDTH-1:0] grid_cols_q;
	logic [CFG_WIDTH-1:0] grid_rows_q;
	logic [31:0]          cols_w;
	logic [31:0]          rows_w;
	logic [ECW-1:0]       cols_eff;
	logic [RW-1:0]        rows_eff;

	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  r0;
	logic [CW-1:0]  c0;
	logic [ECW-1:0] c1;
	logic [RW-1:0]  row_nx;
	logic [CW-1:0]  col_nx;
	logic           bit0;
	logic           in_acc;

	logic          valid_s1;
	logic          bit_s1;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;
	logic          s1_adv;

	logic [1:0] ram_rd;
	logic [1:0] word;
	logic [1:0] wr_data;
	logic [2:0] new_col;
	logic [2:0] win_left;
	logic [2:0] win_mid;
	logic [2:0] right_col;

	logic          is_c0;
	logic          emit;
	logic          last_w;
	lgs_flags_t    flags;
	logic [RW-1:0] rows_p1;
	logic [RW-1:0] rows_p2;
	logic          next_w;
	logic [3:0]    count_w;

	logic       out_valid_q;
	logic       next_alive_q;
	logic [3:0] count_q;
	logic       last_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_COLS_RESET;
			grid_rows_q <= GRID_ROWS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the grid size to the supported range.
	always_comb begin
		cols_w = 32'(grid_cols_q);
		if (cols_w < 32'(MIN_GRID)) begin
			cols_w = 32'(MIN_GRID);
		end else if (cols_w > 32'(MAX_COLS)) begin
			cols_w = 32'(MAX_COLS);
		end
		rows_w = 32'(grid_rows_q);
		if (rows_w < 32'(MIN_GRID)) begin
			rows_w = 32'(MIN_GRID);
		end else if (rows_w > 32'(MAX_ROWS)) begin
			rows_w = 32'(MAX_ROWS);
		end
		cols_eff = cols_w[ECW-1:0];
		rows_eff = rows_w[RW-1:0];
	end

	// Position of the incoming item and of the one after it.
	always_comb begin
		r0 = row_q;
		c0 = col_q;
		if (frame_start) begin
			r0 = '0;
			c0 = '0;
		end else if (ECW'(col_q) >= cols_eff) begin
			c0 = '0;
			if (row_q < RW'(ROW_CAP)) begin
				r0 = row_q + 1'b1;
			end
		end
		c1 = ECW'(c0) + ECW'(1);
		row_nx = r0;
		col_nx = c1[CW-1:0];
		if (c1 >= cols_eff) begin
			col_nx = '0;
			if (r0 < RW'(ROW_CAP)) begin
				row_nx = r0 + 1'b1;
			end
		end
		// Rows past the grid are pads and count as dead.
		bit0 = (r0 < rows_eff) ? alive : 1'b0;
	end

	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc = in_valid && in_ready;
	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	// Stage one: item waiting for its line store data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			fwd_s1 <= valid_s1 && (c_s1 == c0);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bit_s1 <= bit0;
			r_s1 <= r0;
			c_s1 <= c0;
			fwd_data_s1 <= wr_data;
		end
	end

	// Line store: bit 1 is the older row, bit 0 the newer row.
	lgs_ram #(
		.WIDTH (2),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (c_s1),
		.wr_data (wr_data),
		.rd_en   (in_acc),
		.rd_addr (c0),
		.rd_data (ram_rd)
	);

	// Take the column just written if the store read missed it.
	always_comb begin
		word = fwd_s1 ? fwd_data_s1 : ram_rd;
		wr_data = {word[0], bit_s1};
		new_col = {bit_s1, word[0], word[1]};
	end

	// Window: two column cells, fed from the line store column.
	lgs_col_cell u_cell_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (s1_adv),
		.col_in  (win_mid),
		.col_out (win_left)
	);

	lgs_col_cell u_cell_new (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (s1_adv),
		.col_in  (new_col),
		.col_out (win_mid)
	);

	// Edge flags: at column zero the last cell of the row two back is finished.
	always_comb begin
		rows_p1 = rows_eff + RW'(1);
		rows_p2 = rows_eff + RW'(2);
		is_c0 = (c_s1 == '0);
		if (is_c0) begin
			emit = (r_s1 >= RW'(2)) && (r_s1 < rows_p2);
			flags.top_ok = (r_s1 >= RW'(3));
			flags.bot_ok = (r_s1 < rows_p1);
			flags.left_ok = 1'b1;
			last_w = (r_s1 == rows_p1);
			right_col = 3'b000;
		end else begin
			emit = (r_s1 >= RW'(1)) && (r_s1 < rows_p1);
			flags.top_ok = (r_s1 >= RW'(2));
			flags.bot_ok = (r_s1 < rows_eff);
			flags.left_ok = (c_s1 >= CW'(2));
			last_w = 1'b0;
			right_col = new_col;
		end
	end

	lgs_judge u_judge (
		.left_col   (win_left),
		.mid_col    (win_mid),
		.right_col  (right_col),
		.flags      (flags),
		.next_state (next_w),
		.count      (count_w)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			next_alive_q <= next_w;
			count_q <= count_w;
			last_q <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign next_alive = next_alive_q;
	assign neighbour_count = count_q;
	assign last_cell = last_q;

endmodule

`default_nettype wire
